>>> rtl/assert_macros.svh
// Assertion macros used by sha_core.
// Depends on nothing; define ASSERT_OFF to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assert");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assert");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

>>> rtl/sha_pkg.sv
// Constants, types and round functions of the SHA-256 byte stream hasher.
// Used by the top level, the queue, the core and the input interface; depends on nothing.
package sha_pkg;
  localparam int BufDepth = 64;
  localparam int QueueDepth = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef logic [31:0] word_t;

  localparam word_t [0:7] InitHash = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam word_t [0:63] RoundConst = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage

>>> rtl/sha_if.sv
// Valid/ready channel interfaces of the hasher.
// Depends on sha_pkg.
interface sha_in_if import sha_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sha_out_if ();
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

>>> rtl/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher.
// Depends on sha_pkg, sha_if, sha_queue and sha_core.
// Bytes enter a four-word queue; the engine takes one word per cycle while a
// block fills. The word that completes a block stalls the engine while it loads
// the block from the byte-wide buffer RAM into the schedule window, runs the 64
// rounds and one fold. A word marked end of message adds padding up to the end
// of the block and another compression; at a fill of 56 or more a second block
// follows with its own padding and compression. The eight digest words then
// leave one per accepted cycle, most significant first, and the input stays
// stalled until the last one is taken.
module sha256_byte_stream_hasher import sha_pkg::*; #(
  parameter int QDepth = QueueDepth
) (
  input logic clk,
  input logic rst,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);
  logic     q_valid, q_ready;
  in_item_t q_item;

  sha_queue #(.Depth(QDepth)) u_queue (
    .clk, .rst, .in_ch, .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item));

  sha_core u_core (
    .clk, .rst, .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item), .out_ch);
endmodule

>>> rtl/sha_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
module sha_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/sha_queue.sv
// Short FIFO of input words between the front end and the compression engine.
// Depends on sha_pkg.
module sha_queue import sha_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic     clk,
  input  logic     rst,
  sha_in_if.sink   in_ch,
  output logic     out_valid,
  input  logic     out_ready,
  output in_item_t out_item
);
  localparam int AW = $clog2(Depth);
  in_item_t slots [Depth];
  logic [AW-1:0] rd_ptr, wr_ptr;
  logic [AW:0]   count;
  logic push, pop;

  assign in_ch.ready = (count != (AW+1)'(Depth));
  assign out_valid = (count != '0);
  assign out_item = slots[rd_ptr];
  assign push = in_ch.valid && in_ch.ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_ch.payload;
    end
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

>>> rtl/sha_core.sv
// Back end: buffers bytes, pads, runs the 64 rounds and emits the digest.
// Depends on sha_pkg, sha_ram, sha_if and assert_macros.svh.
`include "assert_macros.svh"
module sha_core import sha_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  sha_out_if.source out_ch
);
  localparam logic [2:0] S_IDLE = 3'd0, S_PAD = 3'd1, S_LOAD = 3'd2, S_ROUND = 3'd3,
                         S_FOLD = 3'd4, S_OUT = 3'd5;

  logic [2:0]  state;
  logic [5:0]  fill;
  logic [63:0] bit_count;
  logic [63:0] total;
  logic        closing;    // end of message follows the block being compressed
  logic        final_blk;  // the block being compressed carries the length
  logic [6:0]  step;
  logic [5:0]  pad_pos;
  logic [2:0]  out_idx;
  word_t       cv [8];
  word_t       v [8];
  word_t       w [16];

  logic        we;
  logic [5:0]  waddr, raddr;
  logic [7:0]  wdata, rdata;

  sha_ram #(.Width(8), .Depth(BufDepth)) u_buf (
    .clk, .we, .waddr, .wdata, .raddr, .rdata);

  // The load phase fetches bytes one per cycle: word r is assembled over load steps.
  logic [31:0] byte_acc;
  word_t       w_cur, s1, ch, t1, s0, maj, g0, g1;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    we = 1'b0;
    waddr = fill;
    wdata = in_item.data_byte;
    if (state == S_IDLE && in_valid && in_item.byte_present) begin
      we = 1'b1;
    end else if (state == S_PAD) begin
      we = 1'b1;
      waddr = pad_pos;
      // The length goes into the last eight bytes of whichever block ends the message.
      if (pad_pos == fill && !final_blk) wdata = 8'h80;
      else if (pad_pos >= 6'd56 && (final_blk || fill < 6'd56))
        wdata = total[{~pad_pos[2:0], 3'b111} -: 8];
      else wdata = 8'h00;
    end
  end

  // Bytes are read at step; a finished word enters w on every fourth step.
  assign raddr = step[5:0];

  always_comb begin
    g1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    g0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    w_cur = g1 + w[9] + g0 + w[0];
    s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1 = v[7] + s1 + ch + RoundConst[step[5:0]] + w[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      bit_count <= '0;
      closing <= 1'b0;
      final_blk <= 1'b0;
      step <= '0;
      pad_pos <= '0;
      out_idx <= '0;
      for (int i = 0; i < 8; i++) cv[i] <= InitHash[i];
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            closing <= in_item.end_of_message;
            final_blk <= 1'b0;
            if (in_item.byte_present) begin
              fill <= fill + 6'd1;
              if (fill == 6'd63) begin
                step <= '0;
                state <= S_LOAD;
              end else if (in_item.end_of_message) begin
                total <= bit_count + {55'd0, fill + 6'd1, 3'd0};
                pad_pos <= fill + 6'd1;
                state <= S_PAD;
              end
            end else if (in_item.end_of_message) begin
              total <= bit_count + {55'd0, fill, 3'd0};
              pad_pos <= fill;
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          pad_pos <= pad_pos + 6'd1;
          if (pad_pos == 6'd63) begin
            step <= '0;
            state <= S_LOAD;
            // 0x80 and the length fit only when the pad byte sits below 56.
            if (!final_blk && fill >= 6'd56) begin
              final_blk <= 1'b0;
            end else begin
              final_blk <= 1'b1;
            end
          end
        end
        S_LOAD: begin
          // Load phase: 64 byte reads, one per cycle, feeding the window.
          if (step[1:0] != 2'd0 || step != 7'd0) begin
            byte_acc <= {byte_acc[23:0], rdata};
          end
          if (step == 7'd0) begin
            for (int i = 0; i < 8; i++) v[i] <= cv[i];
          end
          if (step != 7'd0 && step[1:0] == 2'd0) begin
            for (int i = 0; i < 15; i++) w[i] <= w[i+1];
            w[15] <= {byte_acc[23:0], rdata};
          end
          if (step == 7'd64) begin
            step <= '0;
            state <= S_ROUND;
          end else begin
            step <= step + 7'd1;
          end
        end
        S_ROUND: begin
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + s0 + maj;
          // w[0] holds the word of this round; the word sixteen rounds on enters at the top.
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_cur;
          step <= step + 7'd1;
          if (step == 7'd63) state <= S_FOLD;
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) cv[i] <= cv[i] + v[i];
          if (final_blk) begin
            out_idx <= '0;
            state <= S_OUT;
          end else if (closing) begin
            if (fill == 6'd0) begin
              bit_count <= bit_count + 64'd512;
              total <= bit_count + 64'd512;
              pad_pos <= '0;
              fill <= '0;
              state <= S_PAD;
            end else begin
              // Spill block done; next block holds zeros and the length.
              final_blk <= 1'b1;
              pad_pos <= '0;
              fill <= '0;
              state <= S_PAD;
            end
          end else begin
            bit_count <= bit_count + 64'd512;
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) cv[i] <= InitHash[i];
              fill <= '0;
              bit_count <= '0;
              closing <= 1'b0;
              final_blk <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = (state == S_OUT);
  assign out_ch.digest_word = cv[out_idx];
  assign out_ch.word_index = out_idx;
  assign out_ch.last_word = (out_idx == 3'd7);

  `ASSERT_IMPLIES(a_out_only_out, clk, rst, out_ch.valid, !in_ready)
  `ASSERT_NEXT(a_last_to_idle, clk, rst, out_ch.valid && out_ch.ready && out_ch.last_word,
               state == S_IDLE)
  `ASSERT_IMPLIES(a_round_step, clk, rst, state == S_ROUND, step < 7'd64)
endmodule
